### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the constraint checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of clk outside reset.
`define R1CS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define R1CS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define R1CS_ASSERT(label, prop, msg)
`define R1CS_ASSERT_NEVER(label, cond, msg)

`endif

`endif

### rtl/r1cs_pkg.sv
// Shared constants, codes and control types of the constraint checker.
package r1cs_pkg;

  localparam int unsigned WIT_DEPTH = 1024;
  localparam int ADDR_W  = $clog2(WIT_DEPTH);

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int STEP_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] MOD_RESET = 32'd67108859;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE   = 3'd0,
    FN_TERM_A  = 3'd1,
    FN_TERM_B  = 3'd2,
    FN_TERM_C  = 3'd3,
    FN_CLOSE   = 3'd4,
    FN_RESTART = 3'd5
  } func_t;

  typedef struct packed {
    logic start;
    logic add_en;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
    logic eq;
  } mac_sts_t;

endpackage

### rtl/r1cs_in_if.sv
// Input item channel: function code, variable index and value.
interface r1cs_in_if import r1cs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  var_index;
  logic [DATA_W-1:0] value;

  modport source (output valid, output func, output var_index, output value, input ready);
  modport sink   (input valid, input func, input var_index, input value, output ready);
endinterface

### rtl/r1cs_out_if.sv
// Result channel: constraint verdict, running verdict and constraint count.
interface r1cs_out_if import r1cs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               constraint_ok;
  logic               all_ok;
  logic [COUNT_W-1:0] constraint_count;

  modport source (output valid, output constraint_ok, output all_ok,
                  output constraint_count, input ready);
  modport sink   (input valid, input constraint_ok, input all_ok,
                  input constraint_count, output ready);
endinterface

### rtl/r1cs_modmac.sv
// Bit-serial modular multiply-accumulate: (x * y + z) mod m, or x * y mod m with z compare.
`include "assert_macros.svh"

module r1cs_modmac import r1cs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] modulus,
  input  logic [DATA_W-1:0] op_x,
  input  logic [DATA_W-1:0] op_y,
  input  logic [DATA_W-1:0] op_z,
  output mac_sts_t          sts,
  output logic [DATA_W-1:0] result
);

  typedef enum logic [1:0] {PH_IDLE, PH_RED, PH_MUL, PH_FIN} phase_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  phase_t            phase_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DATA_W:0]   m_r;
  logic              add_en_r;
  logic [DATA_W-1:0] x_sh_r, y_sh_r, z_sh_r;
  logic [DATA_W-1:0] yr_r, zr_r, acc_r;
  logic [DATA_W-1:0] res_r;
  logic              eq_r, done_r;

  logic [DATA_W:0]   red_y_v, red_z_v, red_y, red_z;
  logic [DATA_W+1:0] m2, mul_v, mul_red;
  logic [DATA_W:0]   fin_v, fin_red;

  // One restoring reduction step per operand: r = (2r + bit) mod m.
  assign red_y_v = {yr_r, y_sh_r[DATA_W-1]};
  assign red_z_v = {zr_r, z_sh_r[DATA_W-1]};
  assign red_y   = (red_y_v >= m_r) ? red_y_v - m_r : red_y_v;
  assign red_z   = (red_z_v >= m_r) ? red_z_v - m_r : red_z_v;

  // Interleaved multiply step: acc = (2 acc + bit * yr) mod m, value below 3m.
  assign m2    = {m_r, 1'b0};
  assign mul_v = {1'b0, acc_r, 1'b0} + (x_sh_r[DATA_W-1] ? {2'b00, yr_r} : '0);

  always_comb begin
    priority if (mul_v >= m2) begin
      mul_red = mul_v - m2;
    end else if (mul_v >= {1'b0, m_r}) begin
      mul_red = mul_v - {1'b0, m_r};
    end else begin
      mul_red = mul_v;
    end
  end

  assign fin_v   = {1'b0, acc_r} + {1'b0, zr_r};
  assign fin_red = (fin_v >= m_r) ? fin_v - m_r : fin_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == PH_FIN);
      unique case (phase_r)
        PH_IDLE: begin
          if (ctl.start) begin
            // A zero modulus stands for 2^32, which gives plain wraparound.
            m_r      <= {(modulus == '0), modulus};
            add_en_r <= ctl.add_en;
            x_sh_r   <= op_x;
            y_sh_r   <= op_y;
            z_sh_r   <= op_z;
            yr_r     <= '0;
            zr_r     <= '0;
            acc_r    <= '0;
            cnt_r    <= '0;
            phase_r  <= PH_RED;
          end
        end
        PH_RED: begin
          yr_r   <= red_y[DATA_W-1:0];
          zr_r   <= red_z[DATA_W-1:0];
          y_sh_r <= {y_sh_r[DATA_W-2:0], 1'b0};
          z_sh_r <= {z_sh_r[DATA_W-2:0], 1'b0};
          cnt_r  <= cnt_r + STEP_W'(1);
          if (cnt_r == STEP_LAST) begin
            phase_r <= PH_MUL;
          end
        end
        PH_MUL: begin
          acc_r  <= mul_red[DATA_W-1:0];
          x_sh_r <= {x_sh_r[DATA_W-2:0], 1'b0};
          cnt_r  <= cnt_r + STEP_W'(1);
          if (cnt_r == STEP_LAST) begin
            phase_r <= PH_FIN;
          end
        end
        PH_FIN: begin
          res_r   <= add_en_r ? fin_red[DATA_W-1:0] : acc_r;
          eq_r    <= (acc_r == zr_r);
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign sts.done = done_r;
  assign sts.eq   = eq_r;
  assign result   = res_r;

  `R1CS_ASSERT(a_start_when_idle, (ctl.start |-> phase_r == PH_IDLE), "start while busy")
  `R1CS_ASSERT(a_acc_reduced, (phase_r == PH_MUL |-> {1'b0, acc_r} < m_r), "acc not reduced")
  `R1CS_ASSERT(a_yr_reduced, (phase_r == PH_MUL |-> {1'b0, yr_r} < m_r), "y not reduced")
  `R1CS_ASSERT(a_done_after_fin, (done_r |-> $past(phase_r) == PH_FIN), "done without finish step")

endmodule

### rtl/r1cs_constraint_check_core.sv
// Top level of the rank-one constraint checker: witness memory, sums, verdicts.
//
// The block checks rank-one constraints modulo the prime in modulus_r, set
// through cfg_wr_data (a zero modulus means plain 32-bit wraparound). Write
// the witness first, one transfer per entry (func write witness); then send
// each constraint as A, B and C terms, each a coefficient in value and a
// variable in var_index, and finish it with a close transfer, which returns
// one result: whether A * B == C, whether every constraint since the last
// restart held, and a saturating count of closed constraints. Restart clears
// the verdict, the count and the sums but keeps the witness. Operands of any
// size are fully reduced. A witness write, restart or unused code is handled
// in the idle state; a term goes through a witness read and then the one
// bit-serial modular unit, and a close through that unit and then any wait
// for the result register; the unit reduces its operands, then multiplies,
// then finishes. One item is worked on at a time, but a new item is taken
// while a result still waits in the output register. The witness memory has
// no reset and no clearing pass: terms must only refer to entries already
// written. Write the modulus only while the block is idle.
`include "assert_macros.svh"

module r1cs_constraint_check_core import r1cs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  r1cs_in_if.sink           in_ch,
  r1cs_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_TERM, ST_CLOSE, ST_EMIT} state_t;

  state_t             state_r;
  logic [DATA_W-1:0]  modulus_r;
  logic [DATA_W-1:0]  sum_a_r, sum_b_r, sum_c_r;
  logic               running_ok_r;
  logic [COUNT_W-1:0] count_r;
  func_t              func_r;
  logic [DATA_W-1:0]  val_r;
  logic               in_range_r;
  logic               ok_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic               out_all_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [DATA_W-1:0]  witness_mem [WIT_DEPTH];
  logic [DATA_W-1:0]  rd_data_r;

  logic               accept;
  logic               emit;
  func_t              in_func;
  logic               in_range;
  logic [ADDR_W-1:0]  wit_addr;
  logic               wit_we;
  logic [COUNT_W-1:0] count_nxt;

  mac_ctl_t           mac_ctl;
  mac_sts_t           mac_sts;
  logic [DATA_W-1:0]  mac_x, mac_y, mac_z, mac_res;

  // Take a new item only between items; a pending result does not block.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_func     = func_t'(in_ch.func);
  assign in_range    = (32'(in_ch.var_index) < WIT_DEPTH);
  assign wit_addr    = ADDR_W'(in_ch.var_index);
  assign wit_we      = accept && (in_func == FN_WRITE) && in_range;

  // Load the output register once it is free or being emptied.
  assign emit = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // Hold the count at its maximum once reached.
  assign count_nxt = (&count_r) ? count_r : count_r + COUNT_W'(1);

  // Witness memory: one write port, one registered read port, same address.
  always_ff @(posedge clk) begin
    if (wit_we) begin
      witness_mem[wit_addr] <= in_ch.value;
    end
    rd_data_r <= witness_mem[wit_addr];
  end

  // Operand select: a term multiplies coefficient by witness and adds its sum;
  // a close multiplies sum A by sum B and compares against sum C.
  always_comb begin
    // Launch a term once the witness read is back, a close at once.
    mac_ctl.start = (state_r == ST_READ) || (accept && (in_func == FN_CLOSE));
    if (state_r == ST_READ) begin
      mac_x = val_r;
      mac_y = in_range_r ? rd_data_r : '0;
      unique case (func_r)
        FN_TERM_A: mac_z = sum_a_r;
        FN_TERM_B: mac_z = sum_b_r;
        default:   mac_z = sum_c_r;
      endcase
      mac_ctl.add_en = 1'b1;
    end else begin
      mac_x          = sum_a_r;
      mac_y          = sum_b_r;
      mac_z          = sum_c_r;
      mac_ctl.add_en = 1'b0;
    end
  end

  r1cs_modmac u_modmac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .modulus (modulus_r),
    .op_x    (mac_x),
    .op_y    (mac_y),
    .op_z    (mac_z),
    .sts     (mac_sts),
    .result  (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      modulus_r    <= MOD_RESET;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      sum_c_r      <= '0;
      running_ok_r <= 1'b1;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
      // Drop the result once the sink takes the transfer, unless a new one loads.
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            func_r     <= in_func;
            val_r      <= in_ch.value;
            in_range_r <= in_range;
            unique case (in_func)
              FN_TERM_A, FN_TERM_B, FN_TERM_C: state_r <= ST_READ;
              FN_CLOSE:                        state_r <= ST_CLOSE;
              FN_RESTART: begin
                running_ok_r <= 1'b1;
                count_r      <= '0;
                sum_a_r      <= '0;
                sum_b_r      <= '0;
                sum_c_r      <= '0;
              end
              default: begin
                // Witness writes go straight to memory; unused codes do nothing.
              end
            endcase
          end
        end
        ST_READ: begin
          state_r <= ST_TERM;
        end
        ST_TERM: begin
          if (mac_sts.done) begin
            unique case (func_r)
              FN_TERM_A: sum_a_r <= mac_res;
              FN_TERM_B: sum_b_r <= mac_res;
              default:   sum_c_r <= mac_res;
            endcase
            state_r <= ST_IDLE;
          end
        end
        ST_CLOSE: begin
          if (mac_sts.done) begin
            ok_r    <= mac_sts.eq;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Advance once the output register is free or being emptied.
          if (emit) begin
            out_ok_r     <= ok_r;
            out_all_r    <= running_ok_r && ok_r;
            out_count_r  <= count_nxt;
            running_ok_r <= running_ok_r && ok_r;
            count_r      <= count_nxt;
            sum_a_r      <= '0;
            sum_b_r      <= '0;
            sum_c_r      <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.constraint_ok    = out_ok_r;
  assign out_ch.all_ok           = out_all_r;
  assign out_ch.constraint_count = out_count_r;

  `R1CS_ASSERT(a_result_from_close,
    ($rose(out_valid_r) |-> $past(state_r) == ST_EMIT), "result without close")
  `R1CS_ASSERT_NEVER(a_done_unexpected,
    (mac_sts.done && (state_r != ST_TERM) && (state_r != ST_CLOSE)),
    "unit done outside term or close")
  `R1CS_ASSERT(a_sums_clear_after_close,
    (($past(state_r) == ST_EMIT && state_r == ST_IDLE) |->
     (sum_a_r == '0 && sum_b_r == '0 && sum_c_r == '0)), "sums not cleared on close")

endmodule
